[rtl/ftcc_pkg.sv]
// Shared types, constants and calendar helpers for the frame tick calendar clock.
package ftcc_pkg;

  localparam int TICK_W = 32;
  localparam int DIV_CW = $clog2(TICK_W);
  localparam int STEP_W = 12;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] CFG_FPS    = 8'd0;
  localparam logic [7:0] CFG_RESYNC = 8'd1;

  localparam logic [7:0] FPS_RESET    = 8'd60;
  localparam logic [7:0] RESYNC_RESET = 8'd30;

  localparam logic [TICK_W-1:0] MAX_GAP_S = TICK_W'(3600);
  localparam logic [7:0]  SEC_PER_MIN = 8'd60;
  localparam logic [7:0]  MIN_PER_HR  = 8'd60;
  localparam logic [7:0]  HR_PER_DAY  = 8'd24;
  localparam logic [7:0]  MSL_MAX     = 8'd255;
  localparam logic [15:0] CENTURY     = 16'd100;
  localparam logic [15:0] YEAR_MIN    = 16'd2000;
  localparam logic [15:0] YEAR_MAX    = 16'd2199;
  localparam logic [7:0]  MONTH_MAX   = 8'd12;
  localparam logic [7:0]  DAY_MAX     = 8'd31;
  localparam logic [7:0]  HOUR_MAX    = 8'd23;
  localparam logic [7:0]  MINUTE_MAX  = 8'd59;

  // multiplicative inverse of 25 mod 2^16, and the largest product of a multiple of 25
  localparam logic [15:0] INV25      = 16'h5C29;
  localparam logic [15:0] DIV25_LIM  = 16'd2621;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic do_load;
    logic tick_fast;
    logic div_init;
    logic div_step;
    logic gap;
    logic step_init;
    logic step_sec;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic tick_div;
    logic div_last;
    logic gap_long;
    logic secs_zero;
    logic step_last;
    logic out_hold;
  } sts_t;

  function automatic logic [7:0] days_in_month(input logic [7:0] month, input logic leap);
    logic [7:0] d;
    unique case (month)
      8'd2:                         d = leap ? 8'd29 : 8'd28;
      8'd4, 8'd6, 8'd9, 8'd11:      d = 8'd30;
      default:                      d = 8'd31;
    endcase
    return d;
  endfunction

endpackage

[rtl/frame_tick_calendar_clock.sv]
// Load item: applied in EXEC, result captured in DONE. Tick item while valid and counter
// not behind the mark: a bit-serial divide, then the calendar stepper advances N seconds,
// N = seconds advanced (0..3600), one second per cycle; other ticks go from EXEC to DONE.
// One item in flight; the next is taken the cycle after the result enters the output register.
// Synchronous reset: clock invalid, time fields and tick mark zero, 60 frames/s, resync at 30 min.
module frame_tick_calendar_clock (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [31:0] tick_count,
  input  logic        fetch_ok,
  input  logic [7:0]  year_hundreds,
  input  logic [7:0]  year_units,
  input  logic [7:0]  load_month,
  input  logic [7:0]  load_day,
  input  logic [7:0]  load_hour,
  input  logic [7:0]  load_minute,
  input  logic [7:0]  load_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        minute_changed,
  output logic        load_accepted,
  output logic        clock_valid,
  output logic        resync_due,
  output logic [15:0] cur_year,
  output logic [7:0]  cur_month,
  output logic [7:0]  cur_day,
  output logic [7:0]  cur_hour,
  output logic [7:0]  cur_minute,
  output logic [7:0]  cur_second
);

  ftcc_pkg::cmd_t cmd;
  ftcc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  ftcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ftcc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (op),
    .tick_count     (tick_count),
    .fetch_ok       (fetch_ok),
    .year_hundreds  (year_hundreds),
    .year_units     (year_units),
    .load_month     (load_month),
    .load_day       (load_day),
    .load_hour      (load_hour),
    .load_minute    (load_minute),
    .load_second    (load_second),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .minute_changed (minute_changed),
    .load_accepted  (load_accepted),
    .clock_valid    (clock_valid),
    .resync_due     (resync_due),
    .cur_year       (cur_year),
    .cur_month      (cur_month),
    .cur_day        (cur_day),
    .cur_hour       (cur_hour),
    .cur_minute     (cur_minute),
    .cur_second     (cur_second)
  );

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in progress");

  // an accepted load leaves the clock valid; loads never report a minute change
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && load_accepted |-> clock_valid && !minute_changed)
    else $error("load result inconsistent");

  // a valid clock keeps month, hour and minute in range
  a_fields_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && clock_valid |-> cur_month >= 8'd1 && cur_month <= 8'd12 &&
                                 cur_hour <= 8'd23 && cur_minute <= 8'd59)
    else $error("valid clock with field out of range");

endmodule

[rtl/ftcc_ctrl.sv]
// Sequencer for the calendar clock: load, bit-serial divide, then one second per cycle.
module ftcc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ftcc_pkg::sts_t sts,
  output ftcc_pkg::cmd_t cmd
);

  ftcc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ftcc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ftcc_pkg::ST_EXEC;
        end
      end
      ftcc_pkg::ST_EXEC: begin
        if (sts.is_load) begin
          cmd.do_load = 1'b1;
          state_next  = ftcc_pkg::ST_DONE;
        end else if (sts.tick_div) begin
          cmd.div_init = 1'b1;
          state_next   = ftcc_pkg::ST_DIV;
        end else begin
          cmd.tick_fast = 1'b1;
          state_next    = ftcc_pkg::ST_DONE;
        end
      end
      ftcc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ftcc_pkg::ST_CHECK;
        end
      end
      ftcc_pkg::ST_CHECK: begin
        priority if (sts.gap_long) begin
          cmd.gap    = 1'b1;
          state_next = ftcc_pkg::ST_DONE;
        end else if (sts.secs_zero) begin
          state_next = ftcc_pkg::ST_DONE;
        end else begin
          cmd.step_init = 1'b1;
          state_next    = ftcc_pkg::ST_STEP;
        end
      end
      ftcc_pkg::ST_STEP: begin
        cmd.step_sec = 1'b1;
        if (sts.step_last) begin
          state_next = ftcc_pkg::ST_DONE;
        end
      end
      ftcc_pkg::ST_DONE: begin
        if (!sts.out_hold) begin
          cmd.capture = 1'b1;
          state_next  = ftcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ftcc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/ftcc_dp.sv]
// Datapath: item latch, config registers, calendar registers, divider and result register.
module ftcc_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  ftcc_pkg::cmd_t              cmd,
  output ftcc_pkg::sts_t              sts,
  input  logic                        cfg_valid,
  input  logic [7:0]                  cfg_index,
  input  logic [7:0]                  cfg_data,
  input  logic                        op,
  input  logic [31:0]                 tick_count,
  input  logic                        fetch_ok,
  input  logic [7:0]                  year_hundreds,
  input  logic [7:0]                  year_units,
  input  logic [7:0]                  load_month,
  input  logic [7:0]                  load_day,
  input  logic [7:0]                  load_hour,
  input  logic [7:0]                  load_minute,
  input  logic [7:0]                  load_second,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        minute_changed,
  output logic                        load_accepted,
  output logic                        clock_valid,
  output logic                        resync_due,
  output logic [15:0]                 cur_year,
  output logic [7:0]                  cur_month,
  output logic [7:0]                  cur_day,
  output logic [7:0]                  cur_hour,
  output logic [7:0]                  cur_minute,
  output logic [7:0]                  cur_second
);

  localparam int TW = ftcc_pkg::TICK_W;

  // config
  logic [7:0] fps, resync_min;

  // latched item
  logic          op_q, fetch_q;
  logic [TW-1:0] now_q;
  logic [7:0]    yh_q, yu_q, mon_q, day_q, hr_q, min_q, sec_q;

  // clock state
  logic [15:0]   year_reg;
  logic [7:0]    month_reg, day_reg, hour_reg, minute_reg, second_reg, msl;
  logic          valid_flag, leap;
  logic [TW-1:0] start_tick;

  // divider and stepper
  logic [TW-1:0]               dq;
  logic [7:0]                  rem;
  logic [ftcc_pkg::DIV_CW-1:0] div_cnt;
  logic [ftcc_pkg::STEP_W-1:0] step_cnt;
  logic                        changed_q, accepted_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      fps        <= ftcc_pkg::FPS_RESET;
      resync_min <= ftcc_pkg::RESYNC_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ftcc_pkg::CFG_FPS) begin
        fps <= cfg_data;
      end else if (cfg_index == ftcc_pkg::CFG_RESYNC) begin
        resync_min <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= op;
      now_q   <= tick_count[TW-1:0];
      fetch_q <= fetch_ok;
      yh_q    <= year_hundreds;
      yu_q    <= year_units;
      mon_q   <= load_month;
      day_q   <= load_day;
      hr_q    <= load_hour;
      min_q   <= load_minute;
      sec_q   <= load_second;
    end
  end

  // leap year: y%4==0 and (y%25!=0 or y%16==0); registered from year_reg, so it follows it in the next cycle
  logic [15:0] ymul;
  logic        div25;
  assign ymul  = year_reg * ftcc_pkg::INV25;
  assign div25 = (ymul <= ftcc_pkg::DIV25_LIM);

  always_ff @(posedge clk) begin
    leap <= (year_reg[1:0] == 2'd0) && (!div25 || (year_reg[3:0] == 4'd0));
  end

  // load decode and range check
  logic [15:0] year_ld;
  logic        chk_ok;
  assign year_ld = 16'(16'(yh_q) * ftcc_pkg::CENTURY) + 16'(yu_q);
  assign chk_ok  = (mon_q >= 8'd1) && (mon_q <= ftcc_pkg::MONTH_MAX) &&
                   (day_q >= 8'd1) && (day_q <= ftcc_pkg::DAY_MAX) &&
                   (hr_q <= ftcc_pkg::HOUR_MAX) && (min_q <= ftcc_pkg::MINUTE_MAX) &&
                   (year_ld >= ftcc_pkg::YEAR_MIN) && (year_ld <= ftcc_pkg::YEAR_MAX);

  // restoring divider, one quotient bit per cycle
  logic [7:0] fps_eff;
  logic [8:0] trial;
  logic       trial_ge;
  assign fps_eff  = (fps == 8'd0) ? 8'd1 : fps;
  assign trial    = {rem, dq[TW-1]};
  assign trial_ge = (trial >= {1'b0, fps_eff});

  // one second step
  logic [15:0] year_n;
  logic [7:0]  month_n, day_n, hour_n, minute_n, second_n, msl_n;
  logic [7:0]  sec_inc, min_inc, hr_inc, day_inc, dim;
  logic        roll;

  always_comb begin
    sec_inc  = second_reg + 8'd1;
    min_inc  = minute_reg + 8'd1;
    hr_inc   = hour_reg + 8'd1;
    day_inc  = day_reg + 8'd1;
    dim      = ftcc_pkg::days_in_month(month_reg, leap);
    year_n   = year_reg;
    month_n  = month_reg;
    day_n    = day_reg;
    hour_n   = hour_reg;
    minute_n = minute_reg;
    second_n = sec_inc;
    msl_n    = msl;
    roll     = 1'b0;
    if (sec_inc >= ftcc_pkg::SEC_PER_MIN) begin
      second_n = 8'd0;
      roll     = 1'b1;
      if (msl != ftcc_pkg::MSL_MAX) begin
        msl_n = msl + 8'd1;
      end
      minute_n = min_inc;
      if (min_inc >= ftcc_pkg::MIN_PER_HR) begin
        minute_n = 8'd0;
        hour_n   = hr_inc;
        if (hr_inc >= ftcc_pkg::HR_PER_DAY) begin
          hour_n = 8'd0;
          day_n  = day_inc;
          if (day_inc > dim || day_inc == 8'd0) begin
            day_n = 8'd1;
            if (month_reg >= ftcc_pkg::MONTH_MAX) begin
              month_n = 8'd1;
              year_n  = year_reg + 16'd1;
            end else begin
              month_n = month_reg + 8'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year_reg   <= '0;
      month_reg  <= '0;
      day_reg    <= '0;
      hour_reg   <= '0;
      minute_reg <= '0;
      second_reg <= '0;
      valid_flag <= 1'b0;
      start_tick <= '0;
      msl        <= '0;
    end else if (cmd.do_load) begin
      valid_flag <= 1'b0;
      if (fetch_q) begin
        year_reg   <= year_ld;
        month_reg  <= mon_q;
        day_reg    <= day_q;
        hour_reg   <= hr_q;
        minute_reg <= min_q;
        second_reg <= sec_q;
        if (chk_ok) begin
          start_tick <= now_q;
          msl        <= '0;
          valid_flag <= 1'b1;
        end
      end
    end else if (cmd.tick_fast) begin
      // backward wrap of the frame counter: restart the second here
      if (valid_flag) begin
        start_tick <= now_q;
      end
    end else if (cmd.gap) begin
      msl <= resync_min;
    end else if (cmd.step_init) begin
      // start + secs*fps equals now minus the division remainder
      start_tick <= now_q - TW'(rem);
    end else if (cmd.step_sec) begin
      year_reg   <= year_n;
      month_reg  <= month_n;
      day_reg    <= day_n;
      hour_reg   <= hour_n;
      minute_reg <= minute_n;
      second_reg <= second_n;
      msl        <= msl_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dq      <= now_q - start_tick;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      dq      <= {dq[TW-2:0], trial_ge};
      rem     <= trial_ge ? 8'(trial - {1'b0, fps_eff}) : trial[7:0];
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.step_init) begin
      step_cnt <= dq[ftcc_pkg::STEP_W-1:0];
    end else if (cmd.step_sec) begin
      step_cnt <= step_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      changed_q  <= 1'b0;
      accepted_q <= 1'b0;
    end else if (cmd.latch) begin
      changed_q  <= 1'b0;
      accepted_q <= 1'b0;
    end else begin
      if (cmd.do_load && fetch_q && chk_ok) begin
        accepted_q <= 1'b1;
      end
      if (cmd.gap || (cmd.step_sec && roll)) begin
        changed_q <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      minute_changed <= changed_q;
      load_accepted  <= accepted_q;
      clock_valid    <= valid_flag;
      resync_due     <= (msl >= resync_min);
      cur_year       <= year_reg;
      cur_month      <= month_reg;
      cur_day        <= day_reg;
      cur_hour       <= hour_reg;
      cur_minute     <= minute_reg;
      cur_second     <= second_reg;
    end
  end

  always_comb begin
    sts.is_load   = (op_q == ftcc_pkg::OP_LOAD);
    sts.tick_div  = valid_flag && (now_q >= start_tick);
    sts.div_last  = (div_cnt == ftcc_pkg::DIV_CW'(TW - 1));
    sts.gap_long  = (dq > ftcc_pkg::MAX_GAP_S);
    sts.secs_zero = (dq == '0);
    sts.step_last = (step_cnt == ftcc_pkg::STEP_W'(1));
    sts.out_hold  = out_valid && !out_ready;
  end

endmodule

[tb/sv/tb_frame_tick_calendar_clock.sv]
// Self-checking testbench for the frame tick calendar clock: directed and random items.
module tb_frame_tick_calendar_clock;

  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic        op;
    logic [31:0] tick;
    logic        ok;
    logic [7:0]  yh;
    logic [7:0]  yu;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } clock_item_t;

  typedef struct packed {
    logic        minute_changed;
    logic        load_accepted;
    logic        clock_valid;
    logic        resync_due;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } clock_reading_t;

  // Tracks the wall clock the block should hold and the readings it owes.
  class clock_tracker;
    logic [7:0]  fps = 8'd60;
    logic [7:0]  resync = 8'd30;
    logic [15:0] year = '0;
    logic [7:0]  month = '0;
    logic [7:0]  day = '0;
    logic [7:0]  hour = '0;
    logic [7:0]  minute = '0;
    logic [7:0]  second = '0;
    logic        valid = 1'b0;
    logic [31:0] second_mark = '0;
    logic [7:0]  since_load = '0;
    clock_reading_t due_readings[$];
    int items, results, failures, loads_taken, rollovers, gaps, rewinds;

    function void set_reg(logic [7:0] index, logic [7:0] value);
      if (index == ftcc_pkg::CFG_FPS) fps = value;
      else if (index == ftcc_pkg::CFG_RESYNC) resync = value;
    endfunction

    function void take_item(clock_item_t it);
      clock_reading_t r;
      logic [31:0] rate, secs;
      logic [7:0] last;
      logic leap;
      r = '0;
      items++;
      if (it.op == ftcc_pkg::OP_LOAD) begin
        valid = 1'b0;
        if (it.ok) begin
          year = 16'(it.yh) * 16'd100 + 16'(it.yu);
          month = it.month;
          day = it.day;
          hour = it.hour;
          minute = it.minute;
          second = it.second;
          if (month >= 8'd1 && month <= 8'd12 && day >= 8'd1 && day <= 8'd31 &&
              hour <= 8'd23 && minute <= 8'd59 && year >= 16'd2000 && year <= 16'd2199) begin
            second_mark = it.tick;
            since_load = '0;
            valid = 1'b1;
            r.load_accepted = 1'b1;
            loads_taken++;
          end
        end
      end else if (valid) begin
        if (it.tick < second_mark) begin
          second_mark = it.tick;
          rewinds++;
        end else begin
          rate = (fps == 8'd0) ? 32'd1 : {24'd0, fps};
          secs = (it.tick - second_mark) / rate;
          if (secs > 32'd3600) begin
            // long gap: force resync, leave the time alone
            since_load = resync;
            r.minute_changed = 1'b1;
            gaps++;
          end else if (secs > 32'd0) begin
            second_mark = second_mark + secs * rate;
            for (int unsigned n = 0; n < secs; n++) begin
              // 8-bit second: 255 wraps to 0 without a carry
              second = second + 8'd1;
              if (second >= 8'd60) begin
                second = '0;
                r.minute_changed = 1'b1;
                if (since_load != 8'hFF) since_load = since_load + 8'd1;
                minute = minute + 8'd1;
                if (minute >= 8'd60) begin
                  minute = '0;
                  hour = hour + 8'd1;
                  if (hour >= 8'd24) begin
                    hour = '0;
                    leap = (year % 16'd4 == 0) &&
                           ((year % 16'd100 != 0) || (year % 16'd400 == 0));
                    case (month)
                      8'd2:                    last = leap ? 8'd29 : 8'd28;
                      8'd4, 8'd6, 8'd9, 8'd11: last = 8'd30;
                      default:                 last = 8'd31;
                    endcase
                    day = day + 8'd1;
                    if (day > last || day == 8'd0) begin
                      day = 8'd1;
                      if (month >= 8'd12) begin
                        month = 8'd1;
                        year = year + 16'd1;
                      end else begin
                        month = month + 8'd1;
                      end
                    end
                  end
                end
              end
            end
            if (r.minute_changed) rollovers++;
          end
        end
      end
      r.clock_valid = valid;
      r.resync_due = (since_load >= resync);
      r.year = year;
      r.month = month;
      r.day = day;
      r.hour = hour;
      r.minute = minute;
      r.second = second;
      due_readings.push_back(r);
    endfunction

    function string show(clock_reading_t r);
      return $sformatf("chg=%0b acc=%0b valid=%0b resync=%0b %0d-%0d-%0d %0d:%0d:%0d",
                       r.minute_changed, r.load_accepted, r.clock_valid, r.resync_due,
                       r.year, r.month, r.day, r.hour, r.minute, r.second);
    endfunction

    function void match_reading(clock_reading_t got);
      clock_reading_t want;
      results++;
      if (due_readings.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result %0d arrived with nothing outstanding: %s", results, show(got));
        return;
      end
      want = due_readings.pop_front();
      if (got.minute_changed !== want.minute_changed || got.load_accepted !== want.load_accepted ||
          got.clock_valid !== want.clock_valid || got.resync_due !== want.resync_due ||
          got.year !== want.year || got.month !== want.month || got.day !== want.day ||
          got.hour !== want.hour || got.minute !== want.minute || got.second !== want.second) begin
        failures++;
        if (failures <= 10)
          $display("result %0d mismatch\n  exp %s\n  got %s", results, show(want), show(got));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        op;
  logic [31:0] tick_count;
  logic        fetch_ok;
  logic [7:0]  year_hundreds;
  logic [7:0]  year_units;
  logic [7:0]  load_month;
  logic [7:0]  load_day;
  logic [7:0]  load_hour;
  logic [7:0]  load_minute;
  logic [7:0]  load_second;
  logic        out_valid;
  logic        out_ready;
  logic        minute_changed;
  logic        load_accepted;
  logic        clock_valid;
  logic        resync_due;
  logic [15:0] cur_year;
  logic [7:0]  cur_month;
  logic [7:0]  cur_day;
  logic [7:0]  cur_hour;
  logic [7:0]  cur_minute;
  logic [7:0]  cur_second;

  clock_tracker tracker = new();
  int          send_idle_pct = 31;
  int          recv_idle_pct = 83;
  bit          hold_req = 1'b0;
  int          holds_done = 0;
  int          quiet = 0;
  logic [31:0] frame_now = 32'd1000;

  frame_tick_calendar_clock dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.match_reading({minute_changed, load_accepted, clock_valid, resync_due,
                             cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles", quiet);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays up between back-to-back items; it only drops on an idle cycle
  task automatic offer_item(input clock_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    op <= it.op;
    tick_count <= it.tick;
    fetch_ok <= it.ok;
    year_hundreds <= it.yh;
    year_units <= it.yu;
    load_month <= it.month;
    load_day <= it.day;
    load_hour <= it.hour;
    load_minute <= it.minute;
    load_second <= it.second;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.take_item(it);
  endtask

  task automatic load_at(input logic ok, input logic [7:0] yh, input logic [7:0] yu,
                         input logic [7:0] mo, input logic [7:0] dd, input logic [7:0] hh,
                         input logic [7:0] mi, input logic [7:0] ss);
    clock_item_t it;
    it = '{ftcc_pkg::OP_LOAD, frame_now, ok, yh, yu, mo, dd, hh, mi, ss};
    offer_item(it);
  endtask

  task automatic tick_at(input logic [31:0] t);
    clock_item_t it;
    frame_now = t;
    it = '{ftcc_pkg::OP_TICK, t, 1'($urandom_range(1)), 8'($urandom), 8'($urandom),
           8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
    offer_item(it);
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
    @(negedge clk);
    cfg_index <= index;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(index, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.due_readings.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned pick, sub;
    logic [31:0] rate, delta;
    logic [7:0] mo, dd, hh, mi, ss;
    bit near_end;
    rate = (tracker.fps == 8'd0) ? 32'd1 : {24'd0, tracker.fps};
    pick = $urandom_range(99);
    if (pick < 22) begin
      // well-formed load, often parked just before a rollover
      near_end = 1'($urandom_range(1));
      mo = (near_end && $urandom_range(1) == 1) ? 8'd12 : 8'($urandom_range(12, 1));
      dd = near_end ? 8'($urandom_range(31, 28)) : 8'($urandom_range(31, 1));
      hh = near_end ? 8'd23 : 8'($urandom_range(23));
      mi = near_end ? 8'd59 : 8'($urandom_range(59));
      sub = $urandom_range(9);
      if (sub == 0) ss = 8'($urandom_range(255, 60));
      else if (near_end) ss = 8'($urandom_range(59, 50));
      else ss = 8'($urandom_range(59));
      load_at(1'b1, 8'($urandom_range(21, 20)), 8'($urandom_range(99)), mo, dd, hh, mi, ss);
    end else if (pick < 30) begin
      if ($urandom_range(1) == 1) frame_now = $urandom;
      load_at(1'($urandom_range(1)), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 90) begin
      sub = $urandom_range(99);
      if (sub < 55) delta = $urandom_range(3 * rate);
      else if (sub < 80) delta = $urandom_range(120 * rate);
      else if (sub < 90) delta = $urandom_range(3600 * rate);
      else if (sub < 95) delta = 3600 * rate + $urandom_range(rate - 1);
      else delta = 3601 * rate + $urandom_range(1000000);
      tick_at(tracker.second_mark + delta);
    end else if (pick < 95) begin
      tick_at(tracker.second_mark - $urandom_range(5000, 1));
    end else begin
      tick_at($urandom);
    end
  endtask

  task automatic run_phase(input logic [7:0] rate, input logic [7:0] due_min,
                           input int s_pct, input int r_pct, input int count, input bit squeeze);
    wait_idle(16);
    write_reg(ftcc_pkg::CFG_FPS, rate);
    write_reg(ftcc_pkg::CFG_RESYNC, due_min);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (squeeze) begin
      @(posedge clk);
      hold_req = 1'b1;
    end
    repeat (count) random_item();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = ftcc_pkg::OP_LOAD;
    tick_count = '0;
    fetch_ok = 1'b0;
    year_hundreds = '0;
    year_units = '0;
    load_month = '0;
    load_day = '0;
    load_hour = '0;
    load_minute = '0;
    load_second = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset register values (60 frames/s, resync after 30 min)
    tick_at(32'd500);
    load_at(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    load_at(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    load_at(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    frame_now = 32'd1000;
    load_at(1'b1, 8'd20, 8'd0, 8'd2, 8'd28, 8'd23, 8'd59, 8'd58);
    tick_at(32'd1120);
    tick_at(32'd1020);
    tick_at(32'd1079);
    tick_at(32'd1020 + 32'd3601 * 32'd60);
    tick_at(32'd1020 + 32'd3600 * 32'd60);
    load_at(1'b1, 8'd20, 8'd99, 8'd13, 8'd1, 8'd0, 8'd0, 8'd0);
    load_at(1'b1, 8'd20, 8'd50, 8'd5, 8'd32, 8'd10, 8'd10, 8'd10);
    load_at(1'b1, 8'd20, 8'd50, 8'd5, 8'd10, 8'd24, 8'd10, 8'd10);
    load_at(1'b1, 8'd20, 8'd50, 8'd5, 8'd10, 8'd10, 8'd60, 8'd10);
    load_at(1'b1, 8'd19, 8'd99, 8'd5, 8'd10, 8'd10, 8'd10, 8'd10);
    load_at(1'b1, 8'd22, 8'd0, 8'd5, 8'd10, 8'd10, 8'd10, 8'd10);
    load_at(1'b1, 8'd21, 8'd99, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59);
    tick_at(frame_now + 32'd60);
    // 31 February steps into March
    load_at(1'b1, 8'd20, 8'd1, 8'd2, 8'd31, 8'd23, 8'd59, 8'd59);
    tick_at(frame_now + 32'd60);
    load_at(1'b1, 8'd20, 8'd24, 8'd6, 8'd30, 8'd23, 8'd59, 8'd255);
    tick_at(frame_now + 32'd60);
    // odd second byte carries all the way into March of a non-leap century
    load_at(1'b1, 8'd21, 8'd0, 8'd2, 8'd28, 8'd23, 8'd59, 8'd200);
    tick_at(frame_now + 32'd60);
    frame_now = 32'hFFFF_FF00;
    load_at(1'b1, 8'd20, 8'd50, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0);
    tick_at(32'h0000_0010);

    run_phase(8'd1, 8'd1, 31, 83, 35, 1'b0);
    run_phase(8'd255, 8'd255, 83, 31, 35, 1'b0);
    run_phase(8'd0, 8'd2, 0, 0, 20, 1'b0);
    run_phase(8'd25, 8'd30, 0, 0, 30, 1'b1);
    wait_idle(64);

    $display("%0d items, %0d results; %0d loads taken, %0d minute rollovers, %0d long gaps,",
             tracker.items, tracker.results, tracker.loads_taken, tracker.rollovers,
             tracker.gaps);
    $display("%0d counter rewinds, 8 register writes, %0d long output hold-offs",
             tracker.rewinds, holds_done);
    if (tracker.failures == 0 && tracker.due_readings.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
rtl/ftcc_pkg.sv
rtl/ftcc_ctrl.sv
rtl/ftcc_dp.sv
rtl/frame_tick_calendar_clock.sv
tb/sv/tb_frame_tick_calendar_clock.sv
